>>> rtl/lr4_crossover_filter_core_macros.svh
// assertion macros for the crossover core
`ifndef LR4_CROSSOVER_FILTER_CORE_MACROS_SVH
`define LR4_CROSSOVER_FILTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define LR4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LR4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LR4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LR4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/lr4_pkg.sv
package lr4_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int GAIN_W   = 29;
    localparam int TAP_W    = 28;
    localparam int FRAC_W   = 28;
    localparam int ACC_W    = 61;
    localparam int RND_W    = ACC_W - FRAC_W;
    localparam int HIST_D   = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int GP_W     = GAIN_W + 1 + TAP_W;
    localparam int FP_W     = COEF_W + SAMPLE_W;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic        [GAIN_W-1:0]   t_gain;

    typedef enum logic [2:0] {
        REG_FB_ONE   = 3'd0,
        REG_FB_TWO   = 3'd1,
        REG_FB_THREE = 3'd2,
        REG_FB_FOUR  = 3'd3,
        REG_LOW_GAIN = 3'd4,
        REG_HI_GAIN  = 3'd5
    } t_reg_idx;

    localparam t_sample SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    function automatic t_sample saturate(input logic signed [RND_W-1:0] v);
        logic all_zero;
        logic all_one;
        all_zero = ~|v[RND_W-1:SAMPLE_W-1];
        all_one  = &v[RND_W-1:SAMPLE_W-1];
        if (all_zero || all_one) begin
            return v[SAMPLE_W-1:0];
        end else if (v[RND_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

endpackage

>>> rtl/lr4_in_if.sv
interface lr4_in_if;
    logic                valid;
    logic                ready;
    lr4_pkg::t_sample    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/lr4_out_if.sv
interface lr4_out_if;
    logic                valid;
    logic                ready;
    lr4_pkg::t_sample    high_band;
    lr4_pkg::t_sample    low_band;

    modport source (output valid, output high_band, output low_band, input ready);
    modport sink   (input valid, input high_band, input low_band, output ready);
endinterface

>>> rtl/lr4_crossover_filter_core.sv
// fourth-order crossover core: one input sample in, one high-band and one
// low-band sample out per transaction
// input channel i_in carries sample_in (Q1.23); output channel o_out carries
// high_band and low_band (Q1.23, saturated)
// coefficients are written over the apb port: feedback one to four at 0x00
// to 0x0c (Q4.28 signed), low gain at 0x10 and high gain at 0x14 (Q1.28 unsigned)
// write coefficients only while no transaction is in flight
// a sample accepted from i_in is registered in the input register; the sum
// of the gained numerator taps and the four feedback products, rounding and
// saturation then run combinationally, and the result is registered when
// the result register is empty or o_out.ready is high, raising o_out.valid
// throughput: one transaction per cycle while o_out.ready is high; the limit
// is the feedback loop through the output history, closed combinationally
// reset clears coefficients, all three histories and both valid flags
// when a result is pending and o_out.ready is low the result register holds, one
// more sample can sit in the input register, and then i_in.ready drops
`include "lr4_crossover_filter_core_macros.svh"

module lr4_crossover_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lr4_in_if.sink                        i_in,
    lr4_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lr4_pkg::ADDR_W-1:0]    paddr,
    input  logic [lr4_pkg::DATA_W-1:0]    pwdata,
    output logic [lr4_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    lr4_pkg::t_coef   r_fb [lr4_pkg::HIST_D];
    lr4_pkg::t_gain   r_lgain;
    lr4_pkg::t_gain   r_hgain;

    lr4_pkg::t_sample r_pi [lr4_pkg::HIST_D];
    lr4_pkg::t_sample r_ph [lr4_pkg::HIST_D];
    lr4_pkg::t_sample r_pl [lr4_pkg::HIST_D];

    logic             r_in_vld;
    lr4_pkg::t_sample r_x;
    logic             r_out_vld;
    lr4_pkg::t_sample r_hi;
    lr4_pkg::t_sample r_lo;

    logic             w_adv;
    logic             w_wr;
    lr4_pkg::t_reg_idx w_idx;

    logic signed [lr4_pkg::TAP_W-1:0]  w_lp_taps;
    logic signed [lr4_pkg::TAP_W-1:0]  w_hp_taps;
    logic signed [lr4_pkg::GP_W-1:0]   w_lo_gp;
    logic signed [lr4_pkg::GP_W-1:0]   w_hi_gp;
    logic signed [lr4_pkg::ACC_W-1:0]  w_hi_acc;
    logic signed [lr4_pkg::ACC_W-1:0]  w_lo_acc;
    logic signed [lr4_pkg::ACC_W-1:0]  w_hi_rnd;
    logic signed [lr4_pkg::ACC_W-1:0]  w_lo_rnd;
    lr4_pkg::t_sample                  n_hi;
    lr4_pkg::t_sample                  n_lo;

    // config port
    assign pready = 1'b1;
    assign w_idx  = lr4_pkg::t_reg_idx'(paddr[lr4_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lr4_pkg::HIST_D; k++) begin
                r_fb[k] <= '0;
            end
            r_lgain <= '0;
            r_hgain <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                lr4_pkg::REG_FB_ONE:   r_fb[0] <= pwdata;
                lr4_pkg::REG_FB_TWO:   r_fb[1] <= pwdata;
                lr4_pkg::REG_FB_THREE: r_fb[2] <= pwdata;
                lr4_pkg::REG_FB_FOUR:  r_fb[3] <= pwdata;
                lr4_pkg::REG_LOW_GAIN: r_lgain <= pwdata[lr4_pkg::GAIN_W-1:0];
                lr4_pkg::REG_HI_GAIN:  r_hgain <= pwdata[lr4_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lr4_pkg::REG_FB_ONE:   prdata = r_fb[0];
            lr4_pkg::REG_FB_TWO:   prdata = r_fb[1];
            lr4_pkg::REG_FB_THREE: prdata = r_fb[2];
            lr4_pkg::REG_FB_FOUR:  prdata = r_fb[3];
            lr4_pkg::REG_LOW_GAIN: prdata = lr4_pkg::DATA_W'(r_lgain);
            lr4_pkg::REG_HI_GAIN:  prdata = lr4_pkg::DATA_W'(r_hgain);
            default:               prdata = '0;
        endcase
    end

    // handshake
    assign w_adv      = r_in_vld & (~r_out_vld | o_out.ready);
    assign i_in.ready = ~r_in_vld | w_adv;

    assign o_out.valid     = r_out_vld;
    assign o_out.high_band = r_hi;
    assign o_out.low_band  = r_lo;

    // numerator taps
    always_comb begin
        logic signed [lr4_pkg::TAP_W-1:0] x0;
        logic signed [lr4_pkg::TAP_W-1:0] p0;
        logic signed [lr4_pkg::TAP_W-1:0] p1;
        logic signed [lr4_pkg::TAP_W-1:0] p2;
        logic signed [lr4_pkg::TAP_W-1:0] p3;
        x0 = lr4_pkg::TAP_W'(r_x);
        p0 = lr4_pkg::TAP_W'(r_pi[0]);
        p1 = lr4_pkg::TAP_W'(r_pi[1]);
        p2 = lr4_pkg::TAP_W'(r_pi[2]);
        p3 = lr4_pkg::TAP_W'(r_pi[3]);
        w_lp_taps = x0 + (p0 <<< 2) + (p1 <<< 2) + (p1 <<< 1) + (p2 <<< 2) + p3;
        w_hp_taps = x0 - (p0 <<< 2) + (p1 <<< 2) + (p1 <<< 1) - (p2 <<< 2) + p3;
    end

    assign w_lo_gp = $signed({1'b0, r_lgain}) * w_lp_taps;
    assign w_hi_gp = $signed({1'b0, r_hgain}) * w_hp_taps;

    // feedback sums, four independent products per band
    always_comb begin
        logic signed [lr4_pkg::FP_W-1:0] fh;
        logic signed [lr4_pkg::FP_W-1:0] fl;
        w_hi_acc = lr4_pkg::ACC_W'(w_hi_gp);
        w_lo_acc = lr4_pkg::ACC_W'(w_lo_gp);
        for (int k = 0; k < lr4_pkg::HIST_D; k++) begin
            fh = r_fb[k] * r_ph[k];
            fl = r_fb[k] * r_pl[k];
            w_hi_acc = w_hi_acc - lr4_pkg::ACC_W'(fh);
            w_lo_acc = w_lo_acc - lr4_pkg::ACC_W'(fl);
        end
    end

    // round half up, then saturate to the sample range
    assign w_hi_rnd = w_hi_acc + lr4_pkg::ROUND_BIAS;
    assign w_lo_rnd = w_lo_acc + lr4_pkg::ROUND_BIAS;
    assign n_hi = lr4_pkg::saturate($signed(w_hi_rnd[lr4_pkg::ACC_W-1:lr4_pkg::FRAC_W]));
    assign n_lo = lr4_pkg::saturate($signed(w_lo_rnd[lr4_pkg::ACC_W-1:lr4_pkg::FRAC_W]));

    // control and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < lr4_pkg::HIST_D; k++) begin
                r_pi[k] <= '0;
                r_ph[k] <= '0;
                r_pl[k] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_adv) begin
                for (int k = 1; k < lr4_pkg::HIST_D; k++) begin
                    r_pi[k] <= r_pi[k-1];
                    r_ph[k] <= r_ph[k-1];
                    r_pl[k] <= r_pl[k-1];
                end
                r_pi[0] <= r_x;
                r_ph[0] <= n_hi;
                r_pl[0] <= n_lo;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x <= i_in.sample_in;
        end
        if (w_adv) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    `LR4_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_vld, "advance did not fill result register")
    `LR4_ASSERT_NOW(a_hist_high, i_clk, i_rst_n, r_out_vld, (r_hi == r_ph[0] && r_lo == r_pl[0]), "result register and output history disagree")
    `LR4_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_in_vld && r_out_vld && !o_out.ready), (r_in_vld && $stable(r_x) && $stable(r_pi[0])), "stalled sample or history moved")
    `LR4_ASSERT_NOW(a_full_blocks, i_clk, i_rst_n, (r_in_vld && r_out_vld && !o_out.ready), !i_in.ready, "input taken while both stages are full")

endmodule
